// ===== sv/rc_link_packet_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the radio link packet sequencer
// Concurrent checks on the sequencer clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef RC_LINK_PACKET_SEQUENCER_ASSERT_SVH
`define RC_LINK_PACKET_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define RLPS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rlps check failed");
`define RLPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rlps check failed");
`else
`define RLPS_ASSERT_SAME(label, ante, cons)
`define RLPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/rlps_pkg.sv =====
// ----------------------------------------------------------------------------
// Radio link packet sequencer package
// Shared widths, codes, defaults and transfer structures.
// ----------------------------------------------------------------------------
package rlps_pkg;

   localparam int CHAN_FULL_SCALE_DEF = 10000;
   localparam int PACKETS_PER_HOP_DEF = 4;
   localparam int MAX_CHANNELS_DEF    = 12;

   localparam int CHAN_W      = 15;
   localparam int MAG_W       = 15;
   localparam int SCALE_NUM   = 'h640;
   localparam int SCALE_SHIFT = 16;
   localparam int PKT_BYTES   = 16;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [1:0] ACTION_WRITE = 2'd0;
   localparam logic [1:0] ACTION_BUILD = 2'd1;
   localparam logic [1:0] ACTION_BIND  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHIP_ID       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOP_CHANNELS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK_ID       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BOUND   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIND_LENGTH   = 3'd5;

   localparam logic [3:0] KIND_BEACON = 4'h7;
   localparam logic [3:0] KIND_BIND   = 4'ha;
   localparam logic [3:0] KIND_DATA   = 4'hb;
   localparam logic [7:0] SIGN_BASE   = 8'h0b;
   localparam logic [7:0] BIND_ACTIVE = 8'hc0;
   localparam logic [7:0] BIND_ENDED  = 8'h80;

   localparam logic [14:0] BIND_LENGTH_DEF   = 15'h1388;
   localparam logic [3:0]  CHANNEL_COUNT_DEF = 4'd8;

   typedef struct packed {
      logic             valid;
      logic [3:0]       index;
      logic             sign;
      logic [MAG_W-1:0] mag;
   } chan_write_type;

   typedef struct packed {
      logic [PKT_BYTES-1:0][7:0] bytes;
      logic [7:0]                rf_channel;
      logic                      bound_radio;
      logic [3:0]                sop_index;
      logic [15:0]               crc_seed;
      logic                      binding;
   } packet_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== sv/rlps_scale.sv =====
// ----------------------------------------------------------------------------
// Stick channel scaler
// Two-stage pipeline that turns a signed stick value into magnitude and sign,
// scaled by 1600 over full scale through a reciprocal multiply and correction.
// ----------------------------------------------------------------------------
module rlps_scale
   import rlps_pkg::*;
#(
   parameter int CHAN_FULL_SCALE = CHAN_FULL_SCALE_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [3:0]               in_index,
   input  logic signed [CHAN_W-1:0] in_value,
   output chan_write_type           wr,
   output logic                     busy
);

   localparam int RECIP   = (SCALE_NUM << SCALE_SHIFT) / CHAN_FULL_SCALE;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = MAG_W + RECIP_W;
   localparam int Q_W     = PROD_W - SCALE_SHIFT;
   localparam int FS_W    = $clog2(CHAN_FULL_SCALE + 1);
   localparam int TGT_W   = MAG_W + $clog2(SCALE_NUM + 1);
   localparam int CHK_W   = Q_W + 1 + FS_W;
   localparam int CMP_W   = (CHK_W > TGT_W) ? CHK_W : TGT_W;

   logic              s1_valid_ff, s1_valid_in;
   logic [3:0]        s1_index_ff;
   logic              s1_neg_ff;
   logic [MAG_W-1:0]  s1_mag_ff;
   logic              s2_valid_ff, s2_valid_in;
   logic [3:0]        s2_index_ff;
   logic              s2_neg_ff;
   logic [MAG_W-1:0]  s2_mag_ff;
   logic [PROD_W-1:0] s2_prod_ff, s2_prod_in;

   logic [CHAN_W-1:0] raw;
   logic [CHAN_W:0]   abs_wide;
   logic [Q_W-1:0]    q_low;
   logic [Q_W:0]      q_high;
   logic [CMP_W-1:0]  check_lhs;
   logic [CMP_W-1:0]  check_rhs;
   logic [MAG_W-1:0]  mag;

   assign raw         = CHAN_W'(unsigned'(in_value));
   assign abs_wide    = raw[CHAN_W-1] ? (16'h8000 - {1'b0, raw}) : {1'b0, raw};
   assign s1_valid_in = in_valid;
   assign s2_valid_in = s1_valid_ff;
   assign s2_prod_in  = PROD_W'(s1_mag_ff) * PROD_W'(RECIP);

   assign q_low     = s2_prod_ff[PROD_W-1:SCALE_SHIFT];
   assign q_high    = {1'b0, q_low} + (Q_W + 1)'(1);
   assign check_lhs = CMP_W'(q_high) * CMP_W'(CHAN_FULL_SCALE);
   assign check_rhs = CMP_W'(s2_mag_ff) * CMP_W'(SCALE_NUM);
   assign mag       = (check_lhs <= check_rhs) ? MAG_W'(q_high) : MAG_W'(q_low);

   assign wr.valid = s2_valid_ff;
   assign wr.index = s2_index_ff;
   assign wr.sign  = s2_neg_ff && (mag != '0);
   assign wr.mag   = mag;
   assign busy     = s1_valid_ff || s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_index_ff <= in_index;
      s1_neg_ff   <= raw[CHAN_W-1];
      s1_mag_ff   <= abs_wide[MAG_W-1:0];
      s2_index_ff <= s1_index_ff;
      s2_neg_ff   <= s1_neg_ff;
      s2_mag_ff   <= s1_mag_ff;
      s2_prod_ff  <= s2_prod_in;
   end

endmodule

// ===== sv/rlps_front.sv =====
// ----------------------------------------------------------------------------
// Packet sequencer front end
// Accepts commands and register writes, keeps the scaled channel store and
// the bind/data/beacon sequencer, and builds each packet into the queue.
// ----------------------------------------------------------------------------
module rlps_front
   import rlps_pkg::*;
#(
   parameter int CHAN_FULL_SCALE = CHAN_FULL_SCALE_DEF,
   parameter int PACKETS_PER_HOP = PACKETS_PER_HOP_DEF,
   parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_action,
   input  logic [3:0]             req_index,
   input  logic signed [CHAN_W-1:0] req_value,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  queue_status_type       q_status,
   output logic                   push,
   output packet_desc_type        desc
);

   localparam int NROWS = (MAX_CHANNELS / 4 < 1) ? 1 : MAX_CHANNELS / 4;
   localparam int ROW_W = (NROWS > 1) ? $clog2(NROWS) : 1;

   localparam logic [3:0] ST_BIND      = 4'd0;
   localparam logic [3:0] ST_BIND_DATA = 4'd1;
   localparam logic [3:0] ST_BOUND     = 4'd2;
   localparam logic [3:0] ST_BOUND_1   = 4'd3;
   localparam logic [3:0] ST_BOUND_3   = 4'd5;
   localparam logic [3:0] ST_BOUND_10  = 4'd12;

   logic [47:0] chip_id_ff, chip_id_in;
   logic [23:0] hops_ff, hops_in;
   logic [23:0] link_id_ff, link_id_in;
   logic [3:0]  ccount_ff, ccount_in;
   logic        start_bound_ff, start_bound_in;
   logic [14:0] bind_len_ff, bind_len_in;

   logic [3:0]  seq_ff, seq_in;
   logic [15:0] count_ff, count_in;
   logic        bind_flag_ff, bind_flag_in;
   logic [1:0]  group_ff, group_in;
   logic [1:0]  pih_ff, pih_in;
   logic [1:0]  hop_idx_ff, hop_idx_in;
   logic        rbound_ff, rbound_in;

   logic [3:0][MAG_W:0] store_ff [NROWS];

   chan_write_type chan_wr;
   logic           scale_busy;
   logic           accept;
   logic           build;
   logic           wr_in_range;

   logic [3:0][7:0]  cb;
   logic [7:0]       hop_cur, hop_nx1, hop_nx2;
   logic [1:0]       hop_idx_p1, hop_idx_p2;
   logic [15:0]      count_dec;
   logic [15:0]      sfx_count;
   logic [15:0]      final_count;
   logic             is_bind, is_data;
   logic [2:0]       groups_raw, n_groups;
   logic [3:0]       n_nibble;
   logic [3:0][MAG_W:0] row_rd;
   logic [2:0]       group_sum;
   logic [2:0]       pih_sum;
   logic [1:0]       pih_next;
   logic [7:0]       bind_bits;
   logic [7:0]       hop_left;
   logic [7:0]       sign_byte;
   logic [PKT_BYTES-1:0][7:0] pk;
   logic [7:0]       sop_sum;
   logic [7:0]       seed_sum;
   logic [7:0]       seed_byte;

   function automatic logic [3:0] mod_ten(input logic [7:0] x);
      logic [18:0] p;
      logic [7:0]  q;
      logic [7:0]  r;
      p = 19'(x) * 19'd205;
      q = p[18:11];
      r = x - 8'(q * 8'd10);
      return r[3:0];
   endfunction

   function automatic logic [7:0] hop_byte(input logic [23:0] hops, input logic [1:0] sel);
      logic [7:0] b;
      case (sel)
         2'd1:    b = hops[15:8];
         2'd2:    b = hops[23:16];
         default: b = hops[7:0];
      endcase
      return b;
   endfunction

   function automatic logic positive(input logic [15:0] c);
      return !c[15] && (c != 16'd0);
   endfunction

   rlps_scale #(
      .CHAN_FULL_SCALE(CHAN_FULL_SCALE)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept && (req_action == ACTION_WRITE)),
      .in_index (req_index),
      .in_value (req_value),
      .wr       (chan_wr),
      .busy     (scale_busy)
   );

   assign req_ready   = !scale_busy && !q_status.full;
   assign accept      = req_valid && req_ready;
   assign build       = accept && (req_action == ACTION_BUILD);
   assign push        = build;
   assign wr_in_range = {1'b0, chan_wr.index} < 5'(4 * NROWS);

   assign cb         = chip_id_ff[31:0];
   assign hop_idx_p1 = (hop_idx_ff == 2'd2) ? 2'd0 : hop_idx_ff + 2'd1;
   assign hop_idx_p2 = (hop_idx_ff == 2'd0) ? 2'd2 : hop_idx_ff - 2'd1;
   assign hop_cur    = hop_byte(hops_ff, hop_idx_ff);
   assign hop_nx1    = hop_byte(hops_ff, hop_idx_p1);
   assign hop_nx2    = hop_byte(hops_ff, hop_idx_p2);

   assign is_bind   = (seq_ff == ST_BIND);
   assign is_data   = (seq_ff == ST_BIND_DATA) || ((seq_ff >= ST_BOUND) && (seq_ff < ST_BOUND_10));
   assign count_dec = count_ff - 16'd1;
   assign sfx_count = (is_bind || (seq_ff == ST_BIND_DATA)) ? count_dec : count_ff;

   always_comb begin
      if (is_bind || (seq_ff == ST_BIND_DATA)) begin
         final_count = count_dec;
      end else if (is_data && positive(count_ff)) begin
         final_count = count_dec;
      end else begin
         final_count = count_ff;
      end
   end

   assign groups_raw = 3'(({1'b0, ccount_ff} + 5'd3) >> 2);
   always_comb begin
      if (groups_raw == 3'd0) begin
         n_groups = 3'd1;
      end else if (groups_raw > 3'(NROWS)) begin
         n_groups = 3'(NROWS);
      end else begin
         n_groups = groups_raw;
      end
   end
   assign n_nibble = {n_groups[1:0], 2'b00};

   assign row_rd    = store_ff[ROW_W'(group_ff)];
   assign group_sum = {1'b0, group_ff} + 3'd1;
   assign pih_sum   = {1'b0, pih_ff} + 3'd1;
   assign pih_next  = (pih_sum >= 3'(PACKETS_PER_HOP)) ? 2'd0 : pih_sum[1:0];

   assign bind_bits = bind_flag_ff ? (positive(sfx_count) ? BIND_ACTIVE : BIND_ENDED) : 8'd0;
   assign hop_left  = (8'(PACKETS_PER_HOP) - {6'd0, pih_ff} - 8'd1) & 8'h3f;

   always_comb begin
      sign_byte = SIGN_BASE;
      for (int i = 0; i < 4; i++) begin
         sign_byte[7-i] = row_rd[i][MAG_W];
      end
   end

   always_comb begin
      pk = '0;
      if (is_bind) begin
         pk[0] = {n_nibble, KIND_BIND};
         pk[1] = count_dec[7:0];
         pk[2] = count_dec[15:8];
         pk[3] = hop_cur;
         pk[4] = hop_nx1;
         pk[5] = hop_nx2;
         for (int i = 0; i < 4; i++) begin
            pk[6+i] = cb[i];
         end
      end else if (is_data) begin
         pk[0] = {n_nibble, KIND_DATA + {2'b00, group_ff}};
         for (int i = 0; i < 4; i++) begin
            pk[2*i+1] = row_rd[i][7:0];
            pk[2*i+2] = 8'(row_rd[i][MAG_W-1:8]);
         end
         pk[9] = sign_byte;
      end else begin
         pk[0] = {n_nibble, KIND_BEACON};
      end
      pk[10] = bind_bits | hop_left;
      pk[11] = hop_nx1;
      pk[12] = hop_nx2;
      pk[13] = link_id_ff[7:0];
      pk[14] = link_id_ff[15:8];
      pk[15] = link_id_ff[23:16];
      if (is_bind) begin
         for (int i = 0; i < 3; i++) begin
            pk[13+i] = pk[13+i] ^ cb[i];
         end
      end else begin
         for (int j = 1; j < PKT_BYTES; j++) begin
            pk[j] = pk[j] ^ cb[(j-1)%4];
         end
      end
   end

   assign sop_sum   = {cb[0][5:0], 2'b00} + cb[1] + cb[2];
   assign seed_sum  = cb[0] + {6'd0, cb[1][7:6]} + cb[2];
   assign seed_byte = (seed_sum == 8'd0) ? 8'd1 : seed_sum;

   assign desc.bytes       = pk;
   assign desc.rf_channel  = hop_cur;
   assign desc.bound_radio = rbound_ff;
   assign desc.sop_index   = rbound_ff ? mod_ten(sop_sum) : 4'd0;
   assign desc.crc_seed    = rbound_ff ? {seed_byte, seed_byte} : 16'd0;
   assign desc.binding     = positive(final_count);

   always_comb begin
      chip_id_in     = chip_id_ff;
      hops_in        = hops_ff;
      link_id_in     = link_id_ff;
      ccount_in      = ccount_ff;
      start_bound_in = start_bound_ff;
      bind_len_in    = bind_len_ff;
      seq_in         = seq_ff;
      count_in       = count_ff;
      bind_flag_in   = bind_flag_ff;
      group_in       = group_ff;
      pih_in         = pih_ff;
      hop_idx_in     = hop_idx_ff;
      rbound_in      = rbound_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_CHIP_ID:       chip_id_in = csr_data[47:0];
            CSR_HOP_CHANNELS:  hops_in    = csr_data[23:0];
            CSR_LINK_ID:       link_id_in = csr_data[23:0];
            CSR_CHANNEL_COUNT: ccount_in  = csr_data[3:0];
            CSR_START_BOUND: begin
               start_bound_in = csr_data[0];
               group_in       = 2'd0;
               pih_in         = 2'd0;
               hop_idx_in     = 2'd0;
               bind_flag_in   = 1'b0;
               rbound_in      = csr_data[0];
               seq_in         = csr_data[0] ? ST_BOUND_1 : ST_BIND;
               count_in       = csr_data[0] ? 16'd0 : {1'b0, bind_len_ff};
            end
            CSR_BIND_LENGTH:   bind_len_in = csr_data[14:0];
            default: begin
            end
         endcase
      end

      if (accept && (req_action == ACTION_BIND)) begin
         count_in     = {1'b0, bind_len_ff};
         bind_flag_in = 1'b1;
      end

      if (build) begin
         count_in = final_count;
         pih_in   = pih_next;
         if (pih_next == 2'd0) begin
            hop_idx_in = hop_idx_p1;
         end
         if (is_data) begin
            group_in = ((group_sum >= n_groups) || (group_sum > 3'd3)) ? 2'd0 : group_sum[1:0];
         end
         if (is_bind) begin
            seq_in = ST_BIND_DATA;
         end else if (seq_ff == ST_BIND_DATA) begin
            if (positive(count_dec)) begin
               seq_in = ST_BIND;
            end else begin
               seq_in    = ST_BOUND_3;
               rbound_in = 1'b1;
            end
         end else if (is_data) begin
            seq_in = seq_ff + 4'd1;
         end else begin
            seq_in = ST_BOUND_1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_id_ff     <= '0;
         hops_ff        <= '0;
         link_id_ff     <= '0;
         ccount_ff      <= CHANNEL_COUNT_DEF;
         start_bound_ff <= 1'b0;
         bind_len_ff    <= BIND_LENGTH_DEF;
         seq_ff         <= ST_BIND;
         count_ff       <= {1'b0, BIND_LENGTH_DEF};
         bind_flag_ff   <= 1'b0;
         group_ff       <= 2'd0;
         pih_ff         <= 2'd0;
         hop_idx_ff     <= 2'd0;
         rbound_ff      <= 1'b0;
      end else begin
         chip_id_ff     <= chip_id_in;
         hops_ff        <= hops_in;
         link_id_ff     <= link_id_in;
         ccount_ff      <= ccount_in;
         start_bound_ff <= start_bound_in;
         bind_len_ff    <= bind_len_in;
         seq_ff         <= seq_in;
         count_ff       <= count_in;
         bind_flag_ff   <= bind_flag_in;
         group_ff       <= group_in;
         pih_ff         <= pih_in;
         hop_idx_ff     <= hop_idx_in;
         rbound_ff      <= rbound_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NROWS; r++) begin
            store_ff[r] <= '0;
         end
      end else if (chan_wr.valid && wr_in_range) begin
         store_ff[ROW_W'(chan_wr.index[3:2])][chan_wr.index[1:0]] <= {chan_wr.sign, chan_wr.mag};
      end
   end

endmodule

// ===== sv/rlps_queue.sv =====
// ----------------------------------------------------------------------------
// Packet queue
// Two-entry queue of built packets between the front end and the serializer.
// ----------------------------------------------------------------------------
module rlps_queue
   import rlps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  packet_desc_type  push_desc,
   input  logic             pop,
   output packet_desc_type  head_desc,
   output queue_status_type status
);

   packet_desc_type entry_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign head_desc    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== sv/rlps_back.sv =====
// ----------------------------------------------------------------------------
// Packet serializer
// Loads one packet from the queue and sends it one byte per transfer,
// reloading on the last byte so that packets follow without a gap.
// ----------------------------------------------------------------------------
module rlps_back
   import rlps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  packet_desc_type        head_desc,
   input  queue_status_type       q_status,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   packet_desc_type pkt_ff, pkt_in;
   logic            busy_ff, busy_in;
   logic [3:0]      idx_ff, idx_in;
   logic            xfer;
   logic            last;

   assign last       = (idx_ff == 4'd15);
   assign xfer       = busy_ff && rsp_tready;
   assign pop        = !q_status.empty && (!busy_ff || (xfer && last));
   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = last;
   assign rsp_tdata  = {6'd0, pkt_ff.binding, pkt_ff.crc_seed, pkt_ff.sop_index,
                        pkt_ff.bound_radio, pkt_ff.rf_channel, pkt_ff.bytes[idx_ff], idx_ff};

   always_comb begin
      pkt_in  = pkt_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (xfer) begin
         idx_in = idx_ff + 4'd1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         pkt_in  = head_desc;
         busy_in = 1'b1;
         idx_in  = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff <= pkt_in;
   end

endmodule

// ===== sv/rc_link_packet_sequencer.sv =====
// ----------------------------------------------------------------------------
// Radio link packet sequencer
// Builds sixteen-byte bind, data and beacon radio packets from stored stick
// channels and streams them out one byte per transfer.
// ----------------------------------------------------------------------------
// A build command's packet leaves as sixteen byte transfers, one per cycle
// while rsp_tready is high, so steady builds are paced by the byte serializer;
// a two-packet queue lets the input run ahead of the output. After a channel
// write is taken, the input is blocked while the two-stage scaling pipeline
// updates the channel store; start bind and unused commands do not block it.
// Register writes are taken in any cycle and must only be made while no
// packet is in flight. No clearing pass follows reset.
`include "rc_link_packet_sequencer_assert.svh"

module rc_link_packet_sequencer
   import rlps_pkg::*;
#(
   parameter int CHAN_FULL_SCALE = CHAN_FULL_SCALE_DEF,
   parameter int PACKETS_PER_HOP = PACKETS_PER_HOP_DEF,
   parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // channel_index[3:0], channel_value[18:4], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // byte_index[3:0], byte_value[11:4], rf_channel[19:12], bound_radio[20],
   // sop_index[24:21], crc_seed[40:25], binding[41], zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   packet_desc_type  push_desc;
   packet_desc_type  head_desc;
   queue_status_type q_status;
   logic             push;
   logic             pop;

   assign csr_ready = 1'b1;

   rlps_front #(
      .CHAN_FULL_SCALE(CHAN_FULL_SCALE),
      .PACKETS_PER_HOP(PACKETS_PER_HOP),
      .MAX_CHANNELS   (MAX_CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .req_index  (req_tdata[3:0]),
      .req_value  (signed'(req_tdata[18:4])),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .push       (push),
      .desc       (push_desc)
   );

   rlps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .status    (q_status)
   );

   rlps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_desc  (head_desc),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `RLPS_ASSERT_SAME(a_full_blocks_input, q_status.full, !req_tready)
   `RLPS_ASSERT_NEXT(a_write_stalls_input,
      req_tvalid && req_tready && (req_tuser == ACTION_WRITE), !req_tready)
   `RLPS_ASSERT_NEXT(a_byte_index_steps, rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid && (rsp_tdata[3:0] == $past(rsp_tdata[3:0]) + 4'd1))
   `RLPS_ASSERT_NEXT(a_packet_restarts, rsp_tvalid && rsp_tready && rsp_tlast,
      !rsp_tvalid || (rsp_tdata[3:0] == 4'd0))

endmodule
